/* rtl/plrm_pkg.sv */
`timescale 1ns / 1ps

package plrm_pkg;

	localparam int MAX_LEVELS  = 64;
	localparam int CNT_W       = $clog2(MAX_LEVELS + 1);
	localparam int PRICE_W     = 60;
	localparam int PLACES_W    = 5;
	localparam int VOL_W       = 56;
	localparam int IDX_W       = 6;
	localparam int MAX_POW     = 18;
	localparam int DIV_CNT_W   = $clog2(PRICE_W);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [PRICE_W-1:0] BID_START_PRICE = 60'd999999999;
	localparam logic [VOL_W-1:0]   VOL_MAX         = {VOL_W{1'b1}};

	localparam logic SIDE_ASK = 1'b0;
	localparam logic SIDE_BID = 1'b1;

	typedef struct packed {
		logic                side;
		logic [PRICE_W-1:0]  price_value;
		logic [PLACES_W-1:0] price_places;
		logic [VOL_W-1:0]    level_volume;
		logic                first_of_side;
		logic                last_of_side;
	} in_word_t;

	typedef struct packed {
		logic                out_side;
		logic [PRICE_W-1:0]  out_price_value;
		logic [PLACES_W-1:0] out_price_places;
		logic [VOL_W-1:0]    out_volume;
		logic [IDX_W-1:0]    out_index;
		logic                out_last;
		logic                out_empty;
	} out_word_t;

	typedef struct packed {
		logic                side;
		logic [PRICE_W-1:0]  price_value;
		logic [PLACES_W-1:0] price_places;
		logic [VOL_W-1:0]    volume;
		logic                first_of_side;
		logic                last_of_side;
	} q_entry_t;

	typedef struct packed {
		logic                start;
		logic [PRICE_W-1:0]  value;
		logic [PLACES_W-1:0] shift;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [PRICE_W-1:0] quotient;
		logic               rem_nz;
	} div_rsp_t;

	typedef enum logic {
		DV_IDLE,
		DV_RUN
	} dv_state_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_DIV,
		FR_PUSH
	} fr_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CMP,
		BK_WAIT,
		BK_APPLY,
		BK_END
	} bk_state_t;

	function automatic logic [PRICE_W-1:0] pow10(input logic [PLACES_W-1:0] k);
		logic [PRICE_W-1:0] p;
		case (k)
			5'd0:    p = 60'd1;
			5'd1:    p = 60'd10;
			5'd2:    p = 60'd100;
			5'd3:    p = 60'd1000;
			5'd4:    p = 60'd10000;
			5'd5:    p = 60'd100000;
			5'd6:    p = 60'd1000000;
			5'd7:    p = 60'd10000000;
			5'd8:    p = 60'd100000000;
			5'd9:    p = 60'd1000000000;
			5'd10:   p = 60'd10000000000;
			5'd11:   p = 60'd100000000000;
			5'd12:   p = 60'd1000000000000;
			5'd13:   p = 60'd10000000000000;
			5'd14:   p = 60'd100000000000000;
			5'd15:   p = 60'd1000000000000000;
			5'd16:   p = 60'd10000000000000000;
			5'd17:   p = 60'd100000000000000000;
			5'd18:   p = 60'd1000000000000000000;
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

/* rtl/plrm_if.sv */
`timescale 1ns / 1ps

interface plrm_in_if import plrm_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface plrm_out_if import plrm_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* rtl/plrm_div.sv */
`timescale 1ns / 1ps

module plrm_div import plrm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	dv_state_t              state_q, state_nxt;
	logic [PRICE_W-1:0]     quo_q, rem_q, dvsr_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic                   done_q;
	logic [PRICE_W:0]       trial, diff;
	logic                   ge, last_step, long_div;
	logic [PRICE_W-1:0]     rem_nxt;

	always_comb begin
		trial     = {rem_q, quo_q[PRICE_W-1]};
		diff      = trial - {1'b0, dvsr_q};
		ge        = trial >= {1'b0, dvsr_q};
		rem_nxt   = ge ? diff[PRICE_W-1:0] : trial[PRICE_W-1:0];
		last_step = cnt_q == DIV_CNT_W'(PRICE_W - 1);
		long_div  = (req.shift != '0) && (req.shift <= PLACES_W'(MAX_POW));
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			DV_IDLE: begin
				if (req.start && long_div)
					state_nxt = DV_RUN;
			end
			DV_RUN: begin
				if (last_step)
					state_nxt = DV_IDLE;
			end
			default: state_nxt = DV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			done_q  <= 1'b0;
			case (state_q)
				DV_IDLE: begin
					cnt_q <= '0;
					if (req.start && !long_div)
						done_q <= 1'b1;
				end
				DV_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step)
						done_q <= 1'b1;
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DV_IDLE: begin
				if (req.start) begin
					if (req.shift == '0) begin
						quo_q <= req.value;
						rem_q <= '0;
					end else if (!long_div) begin
						quo_q <= '0;
						rem_q <= req.value;
					end else begin
						quo_q  <= req.value;
						rem_q  <= '0;
						dvsr_q <= pow10(req.shift);
					end
				end
			end
			DV_RUN: begin
				quo_q <= {quo_q[PRICE_W-2:0], ge};
				rem_q <= rem_nxt;
			end
			default: begin
				quo_q <= quo_q;
			end
		endcase
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.rem_nz   = |rem_q;

endmodule

/* rtl/plrm_queue.sv */
`timescale 1ns / 1ps

module plrm_queue import plrm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_data,
	output logic     full,
	input  logic     pop,
	output q_entry_t pop_data,
	output logic     empty
);

	q_entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_push, do_pop;

	assign full     = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign empty    = cnt_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

/* rtl/plrm_front.sv */
`timescale 1ns / 1ps

module plrm_front import plrm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	plrm_in_if.sink             level,
	input  logic [PLACES_W-1:0] target_decimals,
	output logic                push,
	output q_entry_t            push_data,
	input  logic                full
);

	fr_state_t state_q, state_nxt;
	q_entry_t  ent_q;
	div_req_t  div_req;
	div_rsp_t  div_rsp;
	logic      accept, round;

	plrm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		level.ready = state_q == FR_IDLE;
		accept      = level.valid && level.ready;
		round       = level.payload.price_places > target_decimals;

		div_req.start = accept && round;
		div_req.value = level.payload.price_value;
		div_req.shift = level.payload.price_places - target_decimals;

		push      = state_q == FR_PUSH;
		push_data = ent_q;

		state_nxt = state_q;
		case (state_q)
			FR_IDLE: begin
				if (accept)
					state_nxt = round ? FR_DIV : FR_PUSH;
			end
			FR_DIV: begin
				if (div_rsp.done)
					state_nxt = FR_PUSH;
			end
			FR_PUSH: begin
				if (!full)
					state_nxt = FR_IDLE;
			end
			default: state_nxt = FR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= FR_IDLE;
		else
			state_q <= state_nxt;
	end

	// round up for asks when anything was cut off
	always_ff @(posedge clk) begin
		if (accept) begin
			ent_q.side          <= level.payload.side;
			ent_q.price_value   <= level.payload.price_value;
			ent_q.price_places  <= round ? target_decimals : level.payload.price_places;
			ent_q.volume        <= level.payload.level_volume;
			ent_q.first_of_side <= level.payload.first_of_side;
			ent_q.last_of_side  <= level.payload.last_of_side;
		end else if (state_q == FR_DIV && div_rsp.done) begin
			ent_q.price_value <= div_rsp.quotient
				+ PRICE_W'((ent_q.side == SIDE_ASK) && div_rsp.rem_nz);
		end
	end

endmodule

/* rtl/plrm_back.sv */
`timescale 1ns / 1ps

module plrm_back import plrm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_entry_t  pop_data,
	input  logic      empty,
	output logic      pop,
	plrm_out_if.source merged
);

	bk_state_t           state_q, state_nxt;
	q_entry_t            item_q;
	logic [PRICE_W-1:0]  last_pv_q;
	logic [PLACES_W-1:0] last_pp_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [VOL_W-1:0]    vol_q;
	logic                adv_q;
	out_word_t           out_q;
	logic                out_valid_q;

	div_req_t            div_req;
	div_rsp_t            div_rsp;
	logic                swap, below_max, has_open, out_free;
	logic [PRICE_W-1:0]  other;
	logic                obig, osmall, dv_gt, dv_lt, adv;
	logic                emit_prev, apply_go, apply_emit, flush_emit;
	logic [VOL_W:0]      vol_sum;
	logic [VOL_W-1:0]    vol_sat;
	logic [IDX_W-1:0]    idx;

	plrm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		pop       = state_q == BK_IDLE && !empty;
		out_free  = !out_valid_q || merged.ready;
		below_max = cnt_q < CNT_W'(MAX_LEVELS);
		has_open  = cnt_q != '0;
		idx       = IDX_W'(cnt_q - 1'b1);

		// bring the side with more places down to the fewer places by dividing it
		swap = item_q.price_places > last_pp_q;
		div_req.start = state_q == BK_CMP && below_max;
		if (swap) begin
			div_req.value = item_q.price_value;
			div_req.shift = item_q.price_places - last_pp_q;
			other         = last_pv_q;
		end else begin
			div_req.value = last_pv_q;
			div_req.shift = last_pp_q - item_q.price_places;
			other         = item_q.price_value;
		end
		obig   = other > div_rsp.quotient;
		osmall = (other < div_rsp.quotient) || (other == div_rsp.quotient && div_rsp.rem_nz);
		dv_gt  = swap ? osmall : obig;
		dv_lt  = swap ? obig : osmall;
		adv    = (item_q.side == SIDE_BID) ? dv_lt : dv_gt;

		vol_sum = {1'b0, vol_q} + {1'b0, item_q.volume};
		vol_sat = vol_sum[VOL_W] ? VOL_MAX : vol_sum[VOL_W-1:0];

		emit_prev  = adv_q && has_open;
		apply_go   = state_q == BK_APPLY && (!emit_prev || out_free);
		apply_emit = apply_go && emit_prev;
		flush_emit = state_q == BK_END && item_q.last_of_side && out_free;

		state_nxt = state_q;
		case (state_q)
			BK_IDLE: begin
				if (pop)
					state_nxt = BK_CMP;
			end
			BK_CMP: begin
				state_nxt = below_max ? BK_WAIT : BK_END;
			end
			BK_WAIT: begin
				if (div_rsp.done)
					state_nxt = BK_APPLY;
			end
			BK_APPLY: begin
				if (apply_go)
					state_nxt = BK_END;
			end
			BK_END: begin
				if (!item_q.last_of_side || out_free)
					state_nxt = BK_IDLE;
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			last_pv_q   <= '0;
			last_pp_q   <= '0;
			cnt_q       <= '0;
			vol_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (pop && pop_data.first_of_side) begin
				cnt_q     <= '0;
				vol_q     <= '0;
				last_pv_q <= (pop_data.side == SIDE_BID) ? BID_START_PRICE : '0;
				last_pp_q <= '0;
			end
			if (apply_go) begin
				if (adv_q) begin
					last_pv_q <= item_q.price_value;
					last_pp_q <= item_q.price_places;
					cnt_q     <= cnt_q + 1'b1;
					vol_q     <= item_q.volume;
				end else if (has_open) begin
					vol_q <= vol_sat;
				end
			end
			if (flush_emit) begin
				cnt_q <= '0;
				vol_q <= '0;
			end
			if (apply_emit || flush_emit)
				out_valid_q <= 1'b1;
			else if (merged.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			item_q <= pop_data;
		if (state_q == BK_WAIT && div_rsp.done)
			adv_q <= adv;
		if (apply_emit || flush_emit) begin
			out_q.out_side <= item_q.side;
			out_q.out_last <= flush_emit;
			if (apply_emit || has_open) begin
				out_q.out_price_value  <= last_pv_q;
				out_q.out_price_places <= last_pp_q;
				out_q.out_volume       <= vol_q;
				out_q.out_index        <= idx;
				out_q.out_empty        <= 1'b0;
			end else begin
				out_q.out_price_value  <= '0;
				out_q.out_price_places <= '0;
				out_q.out_volume       <= '0;
				out_q.out_index        <= '0;
				out_q.out_empty        <= 1'b1;
			end
		end
	end

	assign merged.valid   = out_valid_q;
	assign merged.payload = out_q;

endmodule

/* rtl/price_level_rounding_merger.sv */
`timescale 1ns / 1ps

// Price level rounding merger.
// level: one order-book level per word (side, price value and places, volume,
// first/last of side), valid/ready. merged: merged levels, valid/ready, at most
// two words per input word. cfg_we/cfg_wdata write target_decimals; write only
// while the block is idle.
// The front rounds each price with a radix-2 divider: it takes the word, runs
// a long division when the price carries 1 to 18 more places than
// target_decimals, returns a zero quotient with the whole value as remainder
// when it carries more than 18, skips the divider when it needs no rounding,
// then pushes into a two-word queue. The back pops a word, compares it against
// the open level on a second divider (long division when places differ by 1
// to 18), applies it and closes it; once the level limit is reached it skips
// the divider. Emitting a word holds the back only while merged stalls.
// Front and back overlap, so throughput is set by the slower of the two; each
// takes a new word only once it is through with the last.
// Reset clears the merge state and sets target_decimals to 1.
// A stalled receiver holds the output register; the back then stops, the queue
// fills and level.ready drops.

module price_level_rounding_merger import plrm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	plrm_in_if.sink             level,
	plrm_out_if.source          merged,
	input  logic                cfg_we,
	input  logic [PLACES_W-1:0] cfg_wdata
);

	logic [PLACES_W-1:0] td_q;
	logic                push, full, pop, empty;
	q_entry_t            push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			td_q <= PLACES_W'(1);
		else if (cfg_we)
			td_q <= cfg_wdata;
	end

	plrm_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.level           (level),
		.target_decimals (td_q),
		.push            (push),
		.push_data       (push_data),
		.full            (full)
	);

	plrm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	plrm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_data (pop_data),
		.empty    (empty),
		.pop      (pop),
		.merged   (merged)
	);

endmodule

/* tb/price_level_rounding_merger_checker.sv */
`timescale 1ns / 1ps

module price_level_rounding_merger_checker import plrm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	plrm_in_if                  level,
	plrm_out_if                 merged,
	input  logic                cfg_we,
	input  logic [PLACES_W-1:0] cfg_wdata,
	output int                  errors,
	output int                  pending
);

	localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

	logic [PLACES_W-1:0] target_places;
	logic [PRICE_W-1:0]  open_price;
	logic [PLACES_W-1:0] open_places;
	logic [VOL_W-1:0]    open_vol;
	int unsigned         levels_open;
	int                  mismatches;
	out_word_t           got_word;
	out_word_t           want_word;
	out_word_t           expected_levels[$];

	function automatic logic [63:0] scale10(input logic [63:0] v, input int unsigned k);
		for (int unsigned i = 0; i < k; i++) begin
			if (v > U64_MAX / 64'd10)
				return U64_MAX;
			v = v * 64'd10;
		end
		return v;
	endfunction

	function automatic out_word_t level_word(input logic side, input logic [PRICE_W-1:0] price,
			input logic [PLACES_W-1:0] places, input logic [VOL_W-1:0] vol,
			input int unsigned idx, input logic last, input logic empty);
		out_word_t o;
		o.out_side         = side;
		o.out_price_value  = price;
		o.out_price_places = places;
		o.out_volume       = vol;
		o.out_index        = IDX_W'(idx);
		o.out_last         = last;
		o.out_empty        = empty;
		return o;
	endfunction

	function automatic string word_str(input out_word_t o);
		return $sformatf("side %0d price %0d places %0d volume %0d index %0d last %0b empty %0b",
			o.out_side, o.out_price_value, o.out_price_places, o.out_volume, o.out_index,
			o.out_last, o.out_empty);
	endfunction

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic add_expected(input out_word_t o);
		expected_levels.insert(expected_levels.size(), o);
	endtask

	task automatic predict_merge(input in_word_t w);
		logic [63:0]         pv, q, r, div, a, b;
		logic [PLACES_W-1:0] rp;
		logic [VOL_W:0]      sum;
		int unsigned         shift;
		bit                  advance;
		pv = 64'(w.price_value);
		if (w.first_of_side) begin
			levels_open = 0;
			open_vol    = '0;
			open_price  = (w.side == SIDE_BID) ? BID_START_PRICE : '0;
			open_places = '0;
		end
		if (levels_open < MAX_LEVELS) begin
			if (w.price_places > target_places) begin
				shift = 32'(w.price_places) - 32'(target_places);
				if (shift > 18) begin
					q = '0;
					r = pv;
				end else begin
					div = 64'd1;
					repeat (shift) div = div * 64'd10;
					q = pv / div;
					r = pv % div;
				end
				if (w.side == SIDE_ASK && r != 0)
					q = q + 64'd1;
				rp = target_places;
			end else begin
				q  = pv;
				rp = w.price_places;
			end
			a = q;
			b = 64'(open_price);
			if (rp > open_places)
				b = scale10(b, 32'(rp) - 32'(open_places));
			else
				a = scale10(a, 32'(open_places) - 32'(rp));
			advance = (w.side == SIDE_BID) ? (a < b) : (a > b);
			if (advance) begin
				if (levels_open > 0)
					add_expected(level_word(w.side, open_price, open_places,
						open_vol, levels_open - 1, 1'b0, 1'b0));
				open_price  = q[PRICE_W-1:0];
				open_places = rp;
				open_vol    = w.level_volume;
				levels_open++;
			end else if (levels_open > 0) begin
				sum      = {1'b0, open_vol} + {1'b0, w.level_volume};
				open_vol = sum[VOL_W] ? VOL_MAX : sum[VOL_W-1:0];
			end
		end
		if (w.last_of_side) begin
			if (levels_open > 0)
				add_expected(level_word(w.side, open_price, open_places,
					open_vol, levels_open - 1, 1'b1, 1'b0));
			else
				add_expected(level_word(w.side, '0, '0, '0, 0, 1'b1, 1'b1));
			levels_open = 0;
			open_vol    = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_places = PLACES_W'(1);
			open_price    = '0;
			open_places   = '0;
			open_vol      = '0;
			levels_open   = 0;
			mismatches    = 0;
			expected_levels.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (merged.valid && merged.ready) begin
				got_word = merged.payload;
				if (expected_levels.size() == 0) begin
					report({"unexpected merged word: ", word_str(got_word)});
				end else begin
					want_word = expected_levels.pop_front();
					if (got_word.out_side !== want_word.out_side
							|| got_word.out_price_value !== want_word.out_price_value
							|| got_word.out_price_places !== want_word.out_price_places
							|| got_word.out_volume !== want_word.out_volume
							|| got_word.out_index !== want_word.out_index
							|| got_word.out_last !== want_word.out_last
							|| got_word.out_empty !== want_word.out_empty)
						report({"merged word mismatch: expected ", word_str(want_word),
							"; got ", word_str(got_word)});
				end
			end
			if (level.valid && level.ready)
				predict_merge(level.payload);
			if (cfg_we)
				target_places = cfg_wdata;
			errors  <= mismatches;
			pending <= expected_levels.size();
		end
	end

endmodule

/* tb/price_level_rounding_merger_tb.sv */
`timescale 1ns / 1ps

module price_level_rounding_merger_tb;
	import plrm_pkg::*;

	localparam int          HOLD_CYCLES   = 600;
	localparam int          SETTLE_CYCLES = 600;
	localparam int          CYCLE_LIMIT   = 700000;
	localparam logic [63:0] PRICE_TOP     = 64'd1000000000000000000;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [PLACES_W-1:0] cfg_wdata = '0;
	logic                holding   = 1'b0;
	bit                  idle_en   = 1'b1;
	int                  errors;
	int                  pending;
	int                  items_sent = 0;
	int                  cycles     = 0;
	int                  td_now     = 1;
	event                hold_start;

	plrm_in_if  level_ch ();
	plrm_out_if merged_ch ();

	price_level_rounding_merger u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.level     (level_ch),
		.merged    (merged_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	price_level_rounding_merger_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.level     (level_ch),
		.merged    (merged_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		merged_ch.ready <= !holding && !(idle_en && $urandom_range(99) < 8);
	end

	initial begin
		forever begin
			@(hold_start);
			@(posedge clk);
			holding <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			holding <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pow10_of(input int k);
		logic [63:0] p;
		p = 64'd1;
		repeat (k) p = p * 64'd10;
		return p;
	endfunction

	function automatic in_word_t make_level(input logic side, input logic [63:0] pv,
			input int places, input logic [63:0] vol, input bit first, input bit last);
		in_word_t w;
		w.side          = side;
		w.price_value   = PRICE_W'(pv);
		w.price_places  = PLACES_W'(places);
		w.level_volume  = VOL_W'(vol);
		w.first_of_side = first;
		w.last_of_side  = last;
		return w;
	endfunction

	task automatic send_level(input in_word_t w);
		while (idle_en && $urandom_range(99) < 8) begin
			level_ch.valid <= 1'b0;
			@(posedge clk);
		end
		level_ch.valid   <= 1'b1;
		level_ch.payload <= w;
		@(posedge clk);
		while (!level_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic wait_drained(input int extra);
		level_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_config(input logic [PLACES_W-1:0] v);
		wait_drained(SETTLE_CYCLES);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		td_now = int'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_side(input logic side, input int n, input bit with_first,
			input bit with_last, input bit spread);
		in_word_t    w;
		logic [63:0] price, tick, cap, delta, pv;
		int          places, item_places, r;
		bit          up;
		places = spread ? 2 : $urandom_range(0, 18);
		tick   = pow10_of(places > td_now ? places - td_now : 0);
		cap    = (places >= 10) ? PRICE_TOP : 64'd999999999 * pow10_of(places);
		if (side == SIDE_ASK)
			price = rand64() % (PRICE_TOP / 2);
		else
			price = cap - rand64() % (cap / 2 + 1);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (spread)
				delta = tick + rand64() % tick;
			else if (r < 30)
				delta = '0;
			else if (r < 45)
				delta = rand64() % tick;
			else
				delta = rand64() % (3 * tick) + 1;
			up = (side == SIDE_ASK) == (spread || $urandom_range(9) != 0);
			if (up)
				price = (delta > PRICE_TOP - price) ? PRICE_TOP : price + delta;
			else
				price = (price > delta) ? price - delta : '0;
			item_places = places;
			pv = price;
			if (!spread && $urandom_range(99) < 15) begin
				item_places = $urandom_range(0, 18);
				if (item_places < places)
					pv = price / pow10_of(places - item_places);
				else if (price <= PRICE_TOP / pow10_of(item_places - places))
					pv = price * pow10_of(item_places - places);
				else
					item_places = places;
			end
			r = $urandom_range(99);
			w = make_level(side, pv, item_places,
				(r < 5) ? 64'(VOL_MAX) : (r < 10) ? rand64() : rand64() % 64'd1000000000000,
				with_first && i == 0, with_last && i == n - 1);
			send_level(w);
		end
	endtask

	initial begin
		in_word_t noise;
		int       pick;
		level_ch.valid   = 1'b0;
		level_ch.payload = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_level(make_level(SIDE_ASK, 64'd0, 0, 64'd100, 1, 1));
		send_level(make_level(SIDE_BID, 64'd999999999, 0, 64'd100, 1, 1));
		send_level(make_level(SIDE_ASK, 64'd12345, 3, 64'd5, 1, 0));
		send_level(make_level(SIDE_ASK, 64'd12301, 3, 64'd7, 0, 0));
		send_level(make_level(SIDE_ASK, 64'd1241, 2, 64'd9, 0, 0));
		send_level(make_level(SIDE_ASK, 64'd13, 0, 64'(VOL_MAX), 0, 0));
		send_level(make_level(SIDE_ASK, 64'd130, 1, 64'(VOL_MAX), 0, 0));
		send_level(make_level(SIDE_ASK, 64'd5, 25, 64'd1, 0, 0));
		send_level(make_level(SIDE_ASK, 64'h0FFF_FFFF_FFFF_FFFF, 0, 64'd3, 0, 1));
		send_level(make_level(SIDE_BID, 64'd9999999995, 1, 64'd11, 1, 0));
		send_level(make_level(SIDE_BID, 64'd100, 0, 64'd13, 0, 0));
		send_level(make_level(SIDE_BID, 64'd1000, 1, 64'd17, 0, 0));
		send_level(make_level(SIDE_BID, 64'd9999, 2, 64'd19, 0, 0));
		send_level(make_level(SIDE_BID, 64'd123, 31, 64'd23, 0, 1));
		send_level(make_level(SIDE_ASK, 64'd5, 25, 64'd29, 1, 1));
		send_level(make_level(SIDE_BID, 64'd999999998, 0, 64'd31, 0, 0));
		send_level(make_level(SIDE_ASK, PRICE_TOP, 18, 64'd37, 0, 1));
		send_level(make_level(SIDE_ASK, 64'd7, 0, 64'd0, 1, 0));
		send_level(make_level(SIDE_ASK, 64'd7, 0, 64'd0, 0, 1));
		send_level(make_level(SIDE_BID, 64'd0, 0, 64'(VOL_MAX), 1, 1));

		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0:       write_config(PLACES_W'(0));
				1:       write_config(PLACES_W'(18));
				2:       write_config(PLACES_W'(31));
				3:       write_config(PLACES_W'(2));
				4:       write_config(PLACES_W'($urandom_range(0, 18)));
				5:       write_config(PLACES_W'($urandom_range(0, 31)));
				default: write_config(PLACES_W'(1));
			endcase
			idle_en = (phase != 1);
			if (phase == 2)
				-> hold_start;
			if (phase == 3)
				send_side(SIDE_ASK, 70, 1, 1, 1);
			if (phase == 5)
				send_side(SIDE_BID, 70, 1, 1, 1);
			while (items_sent < 20 + (phase + 1) * 60) begin
				pick = $urandom_range(99);
				if (pick < 75) begin
					send_side(1'($urandom_range(0, 1)), $urandom_range(1, 10), 1, 1, 0);
				end else if (pick < 88) begin
					send_side(1'($urandom_range(0, 1)), $urandom_range(1, 10),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 0);
				end else begin
					noise = make_level(1'($urandom_range(0, 1)), rand64(),
						$urandom_range(0, 31), rand64(),
						$urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0);
					send_level(noise);
				end
				if ($urandom_range(9) == 0)
					wait_drained(0);
			end
			if (phase == 2)
				wait_drained(0);
		end

		wait_drained(SETTLE_CYCLES);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* sim.f */
rtl/plrm_pkg.sv
rtl/plrm_if.sv
rtl/plrm_div.sv
rtl/plrm_queue.sv
rtl/plrm_front.sv
rtl/plrm_back.sv
rtl/price_level_rounding_merger.sv
tb/price_level_rounding_merger_checker.sv
tb/price_level_rounding_merger_tb.sv
